/* hdl/shs_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// shs_pkg
// Shared types and constants of the shuffled hop sequencer.
// ---------------------------------------------------------------------------
package shs_pkg;

  localparam int MAX_CHANNELS = 128;
  localparam int CH_W         = $clog2(MAX_CHANNELS);
  localparam int CNT_W        = $clog2(MAX_CHANNELS + 1);

  localparam logic [31:0] LCG_MUL   = 32'd1664525;
  localparam logic [31:0] LCG_ADD   = 32'd1013904223;
  localparam logic [31:0] SEED_RST  = 32'hBAADF00D;
  localparam logic [23:0] FREQ_MAX  = 24'hFFFFFF;

  typedef enum logic [1:0] {
    CMD_CHECK     = 2'd0,
    CMD_START_FSK = 2'd1,
    CMD_START_LORA = 2'd2,
    CMD_STOP      = 2'd3
  } command_t;

  typedef enum logic [2:0] {
    REG_CHANNEL_COUNT = 3'd0,
    REG_HOP_SEED      = 3'd1,
    REG_BASE_FREQ     = 3'd2,
    REG_SPACING       = 3'd3,
    REG_FSK_INTERVAL  = 3'd4,
    REG_LORA_INTERVAL = 3'd5
  } reg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DECODE, ST_FILL, ST_SEED, ST_LCG, ST_SDIV_GO, ST_SDIV,
    ST_RD_I, ST_RD_J, ST_WR_I, ST_WR_J, ST_START_FIN, ST_HDIV,
    ST_READ, ST_MUL, ST_EMIT
  } state_t;

  typedef struct packed {
    logic capture;
    logic fill_init;
    logic fill_step;
    logic lcg_seed;
    logic lcg_step;
    logic div_shuf;
    logic div_hop;
    logic rd_i;
    logic rd_j;
    logic wr_i;
    logic wr_j;
    logic start_fin;
    logic hop_fin;
    logic stop;
    logic rd_idx;
    logic mul;
    logic emit;
  } ctrl_t;

  typedef struct packed {
    command_t cmd;
    logic     hop_due;
    logic     div_done;
    logic     fill_last;
    logic     shuf_last;
  } stat_t;

endpackage

/* hdl/shuffled_hop_sequencer_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// shuffled_hop_sequencer_top
// Frequency-hop sequencer with a Fisher-Yates shuffled channel table.
// ---------------------------------------------------------------------------
//  channel   ports                               handshake
//  input     in_command, in_now_us               start high while busy low
//  result    out_sent .. out_hops_done           out_valid, one cycle
//  config    cfg_index, cfg_data                 cfg_we, no wait
//
//  A time check or stop runs through decode, read, multiply and emit; a time
//  check that hops also waits on the bit-serial remainder unit. A start
//  fills the table one entry a cycle, then each shuffle step runs the LCG,
//  launches the remainder unit and waits on it, and makes two reads and two
//  writes on the table, which has one read and one write port. Reset is
//  synchronous; the table is not cleared.
//  Results cannot be held off: out_valid flags each one for one cycle.
// ---------------------------------------------------------------------------
module shuffled_hop_sequencer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [31:0] in_now_us,
  output logic        out_valid,
  output logic        out_sent,
  output logic [6:0]  out_channel,
  output logic [23:0] out_freq_khz,
  output logic        out_running,
  output logic [31:0] out_packets_sent,
  output logic [31:0] out_hops_done,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import shs_pkg::*;

  // command and status between controller and datapath
  ctrl_t ctl;
  stat_t stat;

  shs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .ctl       (ctl),
    .busy      (busy),
    .out_valid (out_valid)
  );

  shs_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_command       (in_command),
    .in_now_us        (in_now_us),
    .ctl              (ctl),
    .stat             (stat),
    .out_sent         (out_sent),
    .out_channel      (out_channel),
    .out_freq_khz     (out_freq_khz),
    .out_running      (out_running),
    .out_packets_sent (out_packets_sent),
    .out_hops_done    (out_hops_done)
  );
endmodule

/* hdl/shs_div.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// shs_div
// Restoring remainder unit: 32-bit dividend by 8-bit divisor, one bit a cycle.
// ---------------------------------------------------------------------------
module shs_div (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       go,
  input  logic [31:0] dividend,
  input  logic [7:0] divisor,
  output logic       done,
  output logic [7:0] remainder
);
  logic [31:0] quo_r;
  logic [7:0]  den_r;
  logic [8:0]  rem_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [8:0]  trial;

  assign trial = {rem_r[7:0], quo_r[31]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      quo_r <= dividend;
      den_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      quo_r <= {quo_r[30:0], 1'b0};
      // subtract where the trial remainder covers the divisor
      if (trial >= {1'b0, den_r}) begin
        rem_r <= trial - {1'b0, den_r};
      end else begin
        rem_r <= trial;
      end
    end
  end

  assign done      = done_r;
  assign remainder = rem_r[7:0];
endmodule

/* hdl/shs_dp.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// shs_dp
// Datapath: registers, hop table, LCG, remainder unit, counters and result.
// ---------------------------------------------------------------------------
module shs_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic [1:0]           in_command,
  input  logic [31:0]          in_now_us,
  input  shs_pkg::ctrl_t       ctl,
  output shs_pkg::stat_t       stat,
  output logic                 out_sent,
  output logic [6:0]           out_channel,
  output logic [23:0]          out_freq_khz,
  output logic                 out_running,
  output logic [31:0]          out_packets_sent,
  output logic [31:0]          out_hops_done
);
  import shs_pkg::*;

  logic [7:0]  count_r;
  logic [31:0] seed_r;
  logic [19:0] base_r;
  logic [15:0] spacing_r;
  logic [19:0] fsk_r;
  logic [19:0] lora_r;

  command_t    cmd_r;
  logic [31:0] now_r;
  logic [31:0] last_r;
  logic [CH_W-1:0] idx_r;
  logic        active_r;
  logic        lora_r_sel;
  logic [31:0] pkt_r;
  logic [31:0] hops_r;
  logic [31:0] lcg_r;
  logic [CH_W-1:0] k_r;
  logic [CH_W-1:0] i_r;
  logic [CH_W-1:0] ti_r;
  logic        sent_r;
  logic [CH_W-1:0] ch_r;
  logic [22:0] prod_r;
  logic [23:0] freq_r;

  logic [CH_W-1:0] tbl [MAX_CHANNELS];
  logic [CH_W-1:0] rdata_r;
  logic [CH_W-1:0] raddr;
  logic [CH_W-1:0] waddr;
  logic [CH_W-1:0] wdata;
  logic            we;

  logic [7:0]  n_eff;
  logic [19:0] interval;
  logic [31:0] elapsed;
  logic        div_go;
  logic [31:0] div_a;
  logic [7:0]  div_b;
  logic        div_done;
  logic [7:0]  div_rem;
  logic [7:0]  idx_inc;
  logic [24:0] freq_sum;

  // clamp channel count into [2, MAX_CHANNELS]
  always_comb begin
    if (count_r < 8'd2) begin
      n_eff = 8'd2;
    end else if (count_r > 8'(MAX_CHANNELS)) begin
      n_eff = 8'(MAX_CHANNELS);
    end else begin
      n_eff = count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= 8'd100;
      seed_r    <= SEED_RST;
      base_r    <= 20'd902000;
      spacing_r <= 16'd250;
      fsk_r     <= 20'd6667;
      lora_r    <= 20'd20000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CHANNEL_COUNT: count_r   <= cfg_data[7:0];
        REG_HOP_SEED:      seed_r    <= cfg_data;
        REG_BASE_FREQ:     base_r    <= cfg_data[19:0];
        REG_SPACING:       spacing_r <= cfg_data[15:0];
        REG_FSK_INTERVAL:  fsk_r     <= cfg_data[19:0];
        REG_LORA_INTERVAL: lora_r    <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  assign interval = lora_r_sel ? lora_r : fsk_r;
  assign elapsed  = now_r - last_r;
  assign idx_inc  = {1'b0, idx_r} + 8'd1;

  assign div_go = ctl.div_shuf | ctl.div_hop;
  assign div_a  = ctl.div_hop ? {24'd0, idx_inc} : lcg_r;
  assign div_b  = ctl.div_hop ? n_eff : ({1'b0, i_r} + 8'd1);

  shs_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (div_go),
    .dividend  (div_a),
    .divisor   (div_b),
    .done      (div_done),
    .remainder (div_rem)
  );

  assign stat.cmd       = cmd_r;
  assign stat.hop_due   = active_r && (elapsed >= {12'd0, interval});
  assign stat.div_done  = div_done;
  assign stat.fill_last = ({1'b0, k_r} == n_eff - 8'd1);
  assign stat.shuf_last = (i_r == CH_W'(1));

  // table ports
  always_comb begin
    raddr = idx_r;
    if (ctl.rd_i) begin
      raddr = i_r;
    end else if (ctl.rd_j) begin
      raddr = div_rem[CH_W-1:0];
    end
    we    = ctl.fill_step | ctl.wr_i | ctl.wr_j;
    waddr = k_r;
    wdata = k_r;
    if (ctl.wr_i) begin
      waddr = i_r;
      wdata = rdata_r;
    end else if (ctl.wr_j) begin
      waddr = div_rem[CH_W-1:0];
      wdata = ti_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      tbl[waddr] <= wdata;
    end
    rdata_r <= tbl[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r      <= CMD_CHECK;
      idx_r      <= '0;
      last_r     <= '0;
      active_r   <= 1'b0;
      lora_r_sel <= 1'b0;
      pkt_r      <= '0;
      hops_r     <= '0;
      lcg_r      <= '0;
      sent_r     <= 1'b0;
      k_r        <= '0;
      i_r        <= '0;
    end else begin
      if (ctl.capture) begin
        cmd_r  <= command_t'(in_command);
        sent_r <= 1'b0;
      end
      if (ctl.fill_init) begin
        k_r <= '0;
      end else if (ctl.fill_step) begin
        k_r <= k_r + CH_W'(1);
      end
      if (ctl.lcg_seed) begin
        lcg_r <= seed_r;
        i_r   <= CH_W'(n_eff - 8'd1);
      end else if (ctl.lcg_step) begin
        lcg_r <= lcg_r * LCG_MUL + LCG_ADD;
      end
      if (ctl.wr_j) begin
        i_r <= i_r - CH_W'(1);
      end
      if (ctl.start_fin) begin
        lora_r_sel <= (cmd_r == CMD_START_LORA);
        idx_r      <= '0;
        hops_r     <= '0;
        pkt_r      <= 32'd1;
        last_r     <= now_r;
        active_r   <= 1'b1;
        sent_r     <= 1'b1;
      end
      if (ctl.hop_fin) begin
        idx_r  <= div_rem[CH_W-1:0];
        hops_r <= hops_r + 32'd1;
        pkt_r  <= pkt_r + 32'd1;
        last_r <= now_r;
        sent_r <= 1'b1;
      end
      if (ctl.stop) begin
        active_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      now_r <= in_now_us;
    end
    if (ctl.rd_j) begin
      ti_r <= rdata_r;
    end
    if (ctl.mul) begin
      ch_r   <= rdata_r;
      prod_r <= {16'd0, rdata_r} * {7'd0, spacing_r};
    end
    if (ctl.emit) begin
      freq_r <= (freq_sum > {1'b0, FREQ_MAX}) ? FREQ_MAX : freq_sum[23:0];
    end
  end

  assign freq_sum = {5'd0, base_r} + {2'd0, prod_r};

  assign out_sent         = sent_r;
  assign out_channel      = ch_r;
  assign out_freq_khz     = freq_r;
  assign out_running      = active_r;
  assign out_packets_sent = pkt_r;
  assign out_hops_done    = hops_r;
endmodule

/* hdl/shs_ctrl.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// shs_ctrl
// Controller: sequences decode, table fill, shuffle, hop and result.
// ---------------------------------------------------------------------------
module shs_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  shs_pkg::stat_t stat,
  output shs_pkg::ctrl_t ctl,
  output logic           busy,
  output logic           out_valid
);
  import shs_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= ctl.emit;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    unique case (state_r)
      ST_IDLE: begin
        // take an item only once the previous result has left
        if (start && !valid_r) begin
          ctl.capture = 1'b1;
          state_nxt   = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (stat.cmd)
          CMD_START_FSK, CMD_START_LORA: begin
            ctl.fill_init = 1'b1;
            state_nxt     = ST_FILL;
          end
          CMD_STOP: begin
            ctl.stop  = 1'b1;
            state_nxt = ST_READ;
          end
          default: begin
            if (stat.hop_due) begin
              ctl.div_hop = 1'b1;
              state_nxt   = ST_HDIV;
            end else begin
              state_nxt = ST_READ;
            end
          end
        endcase
      end
      ST_FILL: begin
        ctl.fill_step = 1'b1;
        if (stat.fill_last) begin
          state_nxt = ST_SEED;
        end
      end
      ST_SEED: begin
        ctl.lcg_seed = 1'b1;
        state_nxt    = ST_LCG;
      end
      ST_LCG: begin
        ctl.lcg_step = 1'b1;
        state_nxt    = ST_SDIV_GO;
      end
      ST_SDIV_GO: begin
        ctl.div_shuf = 1'b1;
        state_nxt    = ST_SDIV;
      end
      ST_SDIV: begin
        if (stat.div_done) begin
          state_nxt = ST_RD_I;
        end
      end
      ST_RD_I: begin
        ctl.rd_i  = 1'b1;
        state_nxt = ST_RD_J;
      end
      ST_RD_J: begin
        ctl.rd_j  = 1'b1;
        state_nxt = ST_WR_I;
      end
      ST_WR_I: begin
        ctl.wr_i  = 1'b1;
        state_nxt = ST_WR_J;
      end
      ST_WR_J: begin
        ctl.wr_j  = 1'b1;
        state_nxt = stat.shuf_last ? ST_START_FIN : ST_LCG;
      end
      ST_START_FIN: begin
        ctl.start_fin = 1'b1;
        state_nxt     = ST_READ;
      end
      ST_HDIV: begin
        if (stat.div_done) begin
          ctl.hop_fin = 1'b1;
          state_nxt   = ST_READ;
        end
      end
      ST_READ: begin
        ctl.rd_idx = 1'b1;
        state_nxt  = ST_MUL;
      end
      ST_MUL: begin
        ctl.mul   = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        ctl.emit  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy      = (state_r != ST_IDLE) || valid_r;
  assign out_valid = valid_r;
endmodule

/* tb/shuffled_hop_sequencer_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// shuffled_hop_sequencer_checker
// Watches the item, result and register ports of the hop sequencer, predicts
// the result of every accepted item and compares it field by field.
// ---------------------------------------------------------------------------
module shuffled_hop_sequencer_checker
  import shs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  in_command,
  input  logic [31:0] in_now_us,
  input  logic        out_valid,
  input  logic        out_sent,
  input  logic [6:0]  out_channel,
  input  logic [23:0] out_freq_khz,
  input  logic        out_running,
  input  logic [31:0] out_packets_sent,
  input  logic [31:0] out_hops_done,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic        sent;
    logic [6:0]  channel;
    logic [23:0] freq_khz;
    logic        running;
    logic [31:0] packets_sent;
    logic [31:0] hops_done;
  } hop_report_t;

  hop_report_t expected_reports[$];

  logic [7:0]  count_reg;
  logic [31:0] seed_reg;
  logic [19:0] base_reg;
  logic [15:0] spacing_reg;
  logic [19:0] fsk_iv_reg;
  logic [19:0] lora_iv_reg;

  logic [6:0]  hop_tbl [MAX_CHANNELS];
  int unsigned filled;
  int unsigned hop_idx;
  logic [31:0] last_time;
  logic        hopping;
  logic        lora_mode;
  logic [31:0] pkt_cnt;
  logic [31:0] hop_cnt;
  logic [31:0] lcg;

  assign pending = expected_reports.size();

  function automatic int unsigned live_channels();
    if (count_reg < 2) return 2;
    if (count_reg > MAX_CHANNELS) return MAX_CHANNELS;
    return count_reg;
  endfunction

  // Fill 0..n-1, then Fisher-Yates from the top down.
  function automatic void build_hop_table(int unsigned n);
    int unsigned j;
    logic [6:0]  t;
    for (int unsigned i = 0; i < n; i++) hop_tbl[i] = i[6:0];
    if (n > filled) filled = n;
    lcg = seed_reg;
    for (int unsigned i = n - 1; i > 0; i--) begin
      lcg = lcg * LCG_MUL + LCG_ADD;
      j = lcg % (i + 1);
      t = hop_tbl[i];
      hop_tbl[i] = hop_tbl[j];
      hop_tbl[j] = t;
    end
  endfunction

  function automatic hop_report_t next_hop_report(command_t cmd, logic [31:0] now);
    hop_report_t r;
    logic [31:0] iv;
    logic [63:0] f;
    logic [6:0]  ch;
    r.sent = 1'b0;
    case (cmd)
      CMD_START_FSK, CMD_START_LORA: begin
        build_hop_table(live_channels());
        lora_mode = (cmd == CMD_START_LORA);
        hop_idx   = 0;
        hop_cnt   = 0;
        pkt_cnt   = 1;
        last_time = now;
        hopping   = 1'b1;
        r.sent    = 1'b1;
      end
      CMD_STOP: hopping = 1'b0;
      default: begin
        if (hopping) begin
          iv = lora_mode ? lora_iv_reg : fsk_iv_reg;
          if (now - last_time >= iv) begin
            last_time = now;
            hop_idx   = (hop_idx + 1) % live_channels();
            hop_cnt++;
            pkt_cnt++;
            r.sent    = 1'b1;
          end
        end
      end
    endcase
    ch = (hop_idx < filled) ? hop_tbl[hop_idx] : 7'd0;
    f  = 64'(base_reg) + 64'(ch) * 64'(spacing_reg);
    if (f > 64'(FREQ_MAX)) f = 64'(FREQ_MAX);
    r.channel      = ch;
    r.freq_khz     = f[23:0];
    r.running      = hopping;
    r.packets_sent = pkt_cnt;
    r.hops_done    = hop_cnt;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    hop_report_t e;
    if (!rst_n) begin
      count_reg   <= 8'd100;
      seed_reg    <= SEED_RST;
      base_reg    <= 20'd902000;
      spacing_reg <= 16'd250;
      fsk_iv_reg  <= 20'd6667;
      lora_iv_reg <= 20'd20000;
      filled      = 0;
      hop_idx     = 0;
      last_time   = '0;
      hopping     = 1'b0;
      lora_mode   = 1'b0;
      pkt_cnt     = '0;
      hop_cnt     = '0;
      lcg         = '0;
      expected_reports.delete();
    end else begin
      // Compare first: an item taken at this edge cannot have its result here.
      if (out_valid) begin
        if (expected_reports.size() == 0) begin
          $error("result with nothing expected");
          errors++;
        end else begin
          e = expected_reports.pop_front();
          check_field("sent", e.sent, out_sent);
          check_field("channel", e.channel, out_channel);
          check_field("freq_khz", e.freq_khz, out_freq_khz);
          check_field("running", e.running, out_running);
          check_field("packets_sent", e.packets_sent, out_packets_sent);
          check_field("hops_done", e.hops_done, out_hops_done);
        end
      end
      if (start && !busy)
        expected_reports.push_back(next_hop_report(command_t'(in_command), in_now_us));
      if (cfg_we) begin
        case (reg_index_t'(cfg_index))
          REG_CHANNEL_COUNT: count_reg   <= cfg_data[7:0];
          REG_HOP_SEED:      seed_reg    <= cfg_data;
          REG_BASE_FREQ:     base_reg    <= cfg_data[19:0];
          REG_SPACING:       spacing_reg <= cfg_data[15:0];
          REG_FSK_INTERVAL:  fsk_iv_reg  <= cfg_data[19:0];
          REG_LORA_INTERVAL: lora_iv_reg <= cfg_data[19:0];
          default: ;
        endcase
      end
    end
  end

  initial errors = 0;

endmodule

/* tb/shuffled_hop_sequencer_top_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// shuffled_hop_sequencer_top_tb
// Drives start, stop and time-check items into the hop sequencer across
// several register settings; the checker beside the block predicts and
// compares every result.
// ---------------------------------------------------------------------------
module shuffled_hop_sequencer_top_tb;
  import shs_pkg::*;

  localparam int WATCHDOG_LIMIT = 60000;
  localparam int PHASES         = 10;
  localparam int PHASE_ITEMS    = 200;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_command = CMD_CHECK;
  logic [31:0] in_now_us = '0;
  logic        out_valid;
  logic        out_sent;
  logic [6:0]  out_channel;
  logic [23:0] out_freq_khz;
  logic        out_running;
  logic [31:0] out_packets_sent;
  logic [31:0] out_hops_done;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = REG_CHANNEL_COUNT;
  logic [31:0] cfg_data = '0;
  int          errors;
  int          pending;

  // Local copy of the hop intervals and mode, only to aim timestamps
  // around the point where a hop falls due.
  logic [19:0] fsk_iv;
  logic [19:0] lora_iv;
  logic        lora_on;
  logic [31:0] clock_us;
  logic        allow_idle;
  int          quiet_cycles;

  shuffled_hop_sequencer_top dut (.*);

  shuffled_hop_sequencer_checker checker_i (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: end the run if nothing moves on any port for too long.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || cfg_we || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("shuffled_hop_sequencer_top_tb: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Write one register; hold cfg_we high across back-to-back writes.
  task automatic write_reg(reg_index_t idx, logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    if (idx == REG_FSK_INTERVAL) fsk_iv = data[19:0];
    if (idx == REG_LORA_INTERVAL) lora_iv = data[19:0];
  endtask

  task automatic end_writes();
    cfg_we <= 1'b0;
  endtask

  // Drop start and hold until every expected result is in and the block is free.
  task automatic drain();
    start  <= 1'b0;
    cfg_we <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
  endtask

  // Present one item and hold it until the block takes it.
  task automatic send_item(command_t cmd, logic [31:0] now);
    if (allow_idle && $urandom_range(0, 7) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    start      <= 1'b1;
    in_command <= cmd;
    in_now_us  <= now;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (cmd == CMD_START_FSK) lora_on = 1'b0;
    if (cmd == CMD_START_LORA) lora_on = 1'b1;
  endtask

  // Advance the timestamp by a step around the current interval.
  task automatic send_check();
    logic [31:0] iv;
    iv = lora_on ? lora_iv : fsk_iv;
    case ($urandom_range(0, 9))
      0:       clock_us = $urandom;
      1:       clock_us = clock_us + iv - 1;
      2:       clock_us = clock_us + iv;
      default: clock_us = clock_us + $urandom_range(0, 2 * iv + 2);
    endcase
    send_item(CMD_CHECK, clock_us);
  endtask

  task automatic random_settings();
    logic [7:0] n;
    case ($urandom_range(0, 9))
      0:       n = 8'd0;
      1:       n = 8'd1;
      2:       n = 8'd255;
      3:       n = 8'd128;
      4:       n = 8'($urandom_range(17, 127));
      default: n = 8'($urandom_range(2, 16));
    endcase
    write_reg(REG_CHANNEL_COUNT, n);
    write_reg(REG_HOP_SEED, $urandom);
    write_reg(REG_BASE_FREQ, $urandom_range(0, 20'hFFFFF));
    write_reg(REG_SPACING, $urandom_range(0, 16'hFFFF));
    write_reg(REG_FSK_INTERVAL, ($urandom_range(0, 5) == 0) ? 20'hFFFFF
                                                            : $urandom_range(0, 40));
    write_reg(REG_LORA_INTERVAL, ($urandom_range(0, 5) == 0) ? 20'd0
                                                             : $urandom_range(1, 60));
    end_writes();
  endtask

  initial begin
    fsk_iv     = 20'd6667;
    lora_iv    = 20'd20000;
    lora_on    = 1'b0;
    clock_us   = $urandom;
    allow_idle = 1'b1;
    quiet_cycles = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Fill the whole table first so no entry is read unwritten.
    write_reg(REG_CHANNEL_COUNT, 32'd128);
    write_reg(REG_HOP_SEED, 32'hFFFFFFFF);
    write_reg(REG_BASE_FREQ, 32'hFFFFF);
    write_reg(REG_SPACING, 32'hFFFF);
    write_reg(REG_FSK_INTERVAL, 32'd0);
    write_reg(REG_LORA_INTERVAL, 32'hFFFFF);
    end_writes();
    send_item(CMD_START_FSK, 32'hFFFFFFFF);   // largest base and spacing
    send_item(CMD_CHECK, 32'd0);              // zero interval, wrapped time
    send_item(CMD_CHECK, 32'd0);
    send_item(CMD_STOP, 32'd5);
    send_item(CMD_CHECK, 32'd100);            // not running
    send_item(CMD_STOP, 32'd100);             // stop while stopped
    send_item(CMD_START_LORA, 32'hFFFF0000);
    send_item(CMD_CHECK, 32'hFFFF0000 + 32'hFFFFE);   // just short
    send_item(CMD_CHECK, 32'hFFFF0000 + 32'hFFFFF);   // due exactly
    send_item(CMD_START_LORA, 32'h12345678);  // restart while running
    drain();

    // Counts below the lower bound saturate to two; wrap the index.
    write_reg(REG_CHANNEL_COUNT, 32'd0);
    write_reg(REG_HOP_SEED, 32'd0);
    write_reg(REG_BASE_FREQ, 32'd0);
    write_reg(REG_SPACING, 32'd0);
    write_reg(REG_FSK_INTERVAL, 32'd1);
    end_writes();
    send_item(CMD_START_FSK, 32'd0);
    for (int k = 1; k <= 4; k++) send_item(CMD_CHECK, k);
    drain();

    // Grow the count while running: the next hop uses the new wrap.
    write_reg(REG_CHANNEL_COUNT, 32'd255);
    write_reg(REG_BASE_FREQ, 32'h5A5A5);
    write_reg(REG_SPACING, 32'h0A5A);
    end_writes();
    for (int k = 5; k <= 8; k++) send_item(CMD_CHECK, k);
    drain();

    // Random part: phases of mostly well-formed hop runs with random content.
    for (int p = 0; p < PHASES; p++) begin
      random_settings();
      if (p == PHASES - 1) allow_idle = 1'b0;
      send_item($urandom_range(0, 1) ? CMD_START_LORA : CMD_START_FSK, clock_us);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        case ($urandom_range(0, 39))
          0:       send_item($urandom_range(0, 1) ? CMD_START_LORA : CMD_START_FSK,
                             clock_us);
          1, 2:    send_item(CMD_STOP, $urandom);
          default: send_check();
        endcase
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("shuffled_hop_sequencer_top_tb: done, clean");
    end else begin
      $display("shuffled_hop_sequencer_top_tb: done, errors");
    end
    $finish;
  end

endmodule
